// ===== sv/sat_polygon_circle_collision_assert.svh =====
// ============================================================================
// sat_polygon_circle_collision_assert.svh
// Assertion macros shared by the collision block.
// ============================================================================
`ifndef SAT_POLYGON_CIRCLE_COLLISION_ASSERT_SVH
`define SAT_POLYGON_CIRCLE_COLLISION_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPCC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/spcc_pkg.sv =====
// ============================================================================
// spcc_pkg
// Types and constants of the polygon/circle separating-axis block.
// ============================================================================
`default_nettype none

package spcc_pkg;

    localparam int DATA_W     = 96;
    localparam int USER_IN_W  = 2;
    localparam int USER_OUT_W = 1;

    typedef logic signed [31:0] t_coord;

    // One stored vertex or circle center, x in the upper half
    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_vtx;

    localparam int VTX_W = $bits(t_vtx);

    // 1.0 in Q2.30 and the saturated depth
    localparam logic [31:0] AXIS_ONE  = 32'h4000_0000;
    localparam logic [30:0] DEPTH_SAT = 31'h7FFF_FFFF;

endpackage

`default_nettype wire

// ===== sv/spcc_ram.sv =====
// ============================================================================
// spcc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ============================================================================
`default_nettype none

module spcc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/sat_polygon_circle_collision.sv =====
// ============================================================================
// sat_polygon_circle_collision
// Shape items load at one transfer per cycle while the block is idle; the last
// item starts the test. An edge axis takes edge reads, normalize shifts, a
// 32-step square root, a 32-step divider, then a walk of both shapes through
// the single vertex RAM read port; a circle axis first adds a nearest vertex
// search over the other shape. The result is built in the depth and translation
// states, then loaded into the output register.
// Throughput: one test at a time; the result register frees the input side.
// Reset: synchronous, active low; clears counts, circle flags and the result.
// ============================================================================
`default_nettype none

`include "sat_polygon_circle_collision_assert.svh"

module sat_polygon_circle_collision #(
    parameter int MAX_VERTICES = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [31:0] x, [63:32] y, [94:64] radius, [95] zero
    input  wire logic [spcc_pkg::DATA_W-1:0]         s_axis_tdata,
    // [0] shape_id, [1] is_circle
    input  wire logic [spcc_pkg::USER_IN_W-1:0]      s_axis_tuser,
    input  wire logic                                s_axis_tlast,
    // result stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [31:0] mtv_x, [63:32] mtv_y, [94:64] depth, [95] zero
    output logic      [spcc_pkg::DATA_W-1:0]         m_axis_tdata,
    // [0] collide
    output logic      [spcc_pkg::USER_OUT_W-1:0]     m_axis_tuser
);

    import spcc_pkg::*;

    localparam int DEPTH = 2 * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_VERTICES);
    localparam int CW    = $clog2(MAX_VERTICES + 1);

    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_VERTICES);
    localparam logic [AW-1:0] BASE1   = AW'(MAX_VERTICES);

    // Sequencer states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_START   = 5'd1;
    localparam logic [4:0] S_EDGE    = 5'd2;
    localparam logic [4:0] S_E_RD1   = 5'd3;
    localparam logic [4:0] S_E_RD2   = 5'd4;
    localparam logic [4:0] S_CIRC    = 5'd5;
    localparam logic [4:0] S_C_CTR   = 5'd6;
    localparam logic [4:0] S_C_RD    = 5'd7;
    localparam logic [4:0] S_C_D     = 5'd8;
    localparam logic [4:0] S_C_SQX   = 5'd9;
    localparam logic [4:0] S_C_SQY   = 5'd10;
    localparam logic [4:0] S_C_CMP   = 5'd11;
    localparam logic [4:0] S_AX_ABS  = 5'd12;
    localparam logic [4:0] S_AX_NORM = 5'd13;
    localparam logic [4:0] S_AX_SQX  = 5'd14;
    localparam logic [4:0] S_AX_SQY  = 5'd15;
    localparam logic [4:0] S_AX_SUM  = 5'd16;
    localparam logic [4:0] S_AX_SQRT = 5'd17;
    localparam logic [4:0] S_AX_DIV  = 5'd18;
    localparam logic [4:0] S_AX_SET  = 5'd19;
    localparam logic [4:0] S_PR_RD   = 5'd20;
    localparam logic [4:0] S_PR_MX   = 5'd21;
    localparam logic [4:0] S_PR_MY   = 5'd22;
    localparam logic [4:0] S_PR_ACC  = 5'd23;
    localparam logic [4:0] S_PR_UPD  = 5'd24;
    localparam logic [4:0] S_OV      = 5'd25;
    localparam logic [4:0] S_OV2     = 5'd26;
    localparam logic [4:0] S_FIN     = 5'd27;
    localparam logic [4:0] S_MX      = 5'd28;
    localparam logic [4:0] S_MY      = 5'd29;
    localparam logic [4:0] S_MW      = 5'd30;
    localparam logic [4:0] S_OUT     = 5'd31;

    // Shape s occupies the RAM rows [s*MAX_VERTICES, (s+1)*MAX_VERTICES)
    function automatic logic [AW-1:0] f_addr(input logic s, input logic [CW-1:0] i);
        logic [AW-1:0] off;
        off = AW'(i[IW-1:0]);
        return s ? BASE1 + off : off;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [4:0]          r_state;
    logic [CW-1:0]       r_cnt [2];
    logic                r_circ [2];
    logic [30:0]         r_rad [2];

    logic [1:0]          r_s;        // shape being walked for axes
    logic [CW-1:0]       r_i;        // edge index or nearest-vertex index
    logic                r_pass;     // 0: edge axes, 1: circle axes
    t_coord              r_px, r_py; // edge start or circle center
    logic signed [33:0]  r_dx, r_dy; // axis direction before normalization
    logic [32:0]         r_mx, r_my;
    logic                r_sx, r_sy;
    logic [65:0]         r_sq;
    logic [63:0]         r_n, r_r, r_b;
    logic [32:0]         r_remx, r_remy;
    logic [31:0]         r_qx, r_qy;
    logic [4:0]          r_k;
    t_coord              r_ax, r_ay;

    logic                r_ps;
    logic [CW-1:0]       r_pi;
    t_coord              r_vy;
    logic signed [63:0]  r_pacc, r_d, r_lo, r_hi, r_alo, r_ahi, r_top, r_bot;
    logic                r_dirpos;

    logic                r_found;
    logic [63:0]         r_best;
    t_coord              r_bax, r_bay;
    logic                r_bdir;

    logic                r_have;
    logic [65:0]         r_bd2;
    logic signed [32:0]  r_tdx, r_tdy, r_bdx, r_bdy;

    logic                r_hit;
    logic [30:0]         r_depth;
    logic [31:0]         r_mtvx, r_mtvy;

    logic                r_ovalid;
    logic [DATA_W-1:0]   r_odata;
    logic                r_ouser;

    // ------------------------------------------------------------------
    // Input side: load one vertex or circle per transfer
    // ------------------------------------------------------------------
    logic          in_acc, in_shape, in_circ, ram_we;
    logic [CW-1:0] in_eff;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [VTX_W-1:0] ram_wdata, ram_rdata;
    t_vtx          rd_v;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_shape = s_axis_tuser[0];
    assign in_circ  = s_axis_tuser[1];
    // a polygon item on a circle shape starts that shape over
    assign in_eff   = r_circ[in_shape] ? '0 : r_cnt[in_shape];
    assign ram_we   = in_acc && (in_circ || (in_eff < CNT_MAX));
    assign ram_waddr = f_addr(in_shape, in_circ ? '0 : in_eff);
    assign ram_wdata = {s_axis_tdata[31:0], s_axis_tdata[63:32]};

    // ------------------------------------------------------------------
    // Vertex store
    // ------------------------------------------------------------------
    logic [CW-1:0] e_j;
    assign e_j = ((r_i + CW'(1)) == r_cnt[r_s[0]]) ? '0 : r_i + CW'(1);

    always_comb begin
        unique case (r_state)
            S_EDGE:  ram_raddr = f_addr(r_s[0], r_i);
            S_E_RD1: ram_raddr = f_addr(r_s[0], e_j);
            S_CIRC:  ram_raddr = f_addr(r_s[0], '0);
            S_C_RD:  ram_raddr = f_addr(~r_s[0], r_i);
            S_PR_RD: ram_raddr = f_addr(r_ps, r_pi);
            default: ram_raddr = '0;
        endcase
    end

    spcc_ram #(
        .WIDTH (VTX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_v = t_vtx'(ram_rdata);

    // ------------------------------------------------------------------
    // Shared multiplier, registered product
    // ------------------------------------------------------------------
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic signed [67:0] r_prod;
    logic [31:0]        bax_abs, bay_abs;

    assign bax_abs = r_bax[31] ? 32'(-r_bax) : 32'(r_bax);
    assign bay_abs = r_bay[31] ? 32'(-r_bay) : 32'(r_bay);

    always_comb begin
        unique case (r_state)
            S_AX_SQX: begin
                mul_a = $signed({1'b0, r_mx});
                mul_b = $signed({1'b0, r_mx});
            end
            S_AX_SQY: begin
                mul_a = $signed({1'b0, r_my});
                mul_b = $signed({1'b0, r_my});
            end
            // a signed square equals the square of the magnitude
            S_C_SQX: begin
                mul_a = 34'(r_tdx);
                mul_b = 34'(r_tdx);
            end
            S_C_SQY: begin
                mul_a = 34'(r_tdy);
                mul_b = 34'(r_tdy);
            end
            S_PR_MX: begin
                mul_a = 34'(rd_v.x);
                mul_b = 34'(r_ax);
            end
            S_PR_MY: begin
                mul_a = 34'(r_vy);
                mul_b = 34'(r_ay);
            end
            S_MX: begin
                mul_a = $signed({2'b0, bax_abs});
                mul_b = $signed({3'b0, r_depth});
            end
            S_MY: begin
                mul_a = $signed({2'b0, bay_abs});
                mul_b = $signed({3'b0, r_depth});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 68'(mul_a) * 68'(mul_b);

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic signed [32:0] e_dx, e_dy, c_dx, c_dy;
    logic signed [33:0] ab_x, ab_y;
    logic [32:0]        nm_m;
    logic [63:0]        sq_t, sq_rn;
    logic [32:0]        dv_len, dv_tx, dv_ty;
    logic               dv_gx, dv_gy;
    logic [31:0]        set_cx, set_cy;
    logic [65:0]        c_sum;
    logic signed [63:0] pr_d, pr_rr, pr_lo, pr_hi;
    logic               pr_circ, pr_done;
    logic [CW-1:0]      pr_next;
    logic [63:0]        ov_val;
    logic [33:0]        fin_dep;
    logic [31:0]        mtv_mag;
    logic               out_load;

    assign e_dx = 33'(rd_v.x) - 33'(r_px);
    assign e_dy = 33'(rd_v.y) - 33'(r_py);
    assign c_dx = e_dx;
    assign c_dy = e_dy;

    assign ab_x = r_dx[33] ? -r_dx : r_dx;
    assign ab_y = r_dy[33] ? -r_dy : r_dy;
    assign nm_m = (r_mx > r_my) ? r_mx : r_my;

    // one digit pair of the integer square root per cycle
    assign sq_t  = r_r + r_b;
    assign sq_rn = (r_n >= sq_t) ? (r_r >> 1) + r_b : (r_r >> 1);

    // restoring divider: both components against the same length
    assign dv_len = {1'b0, r_r[31:0]};
    assign dv_tx  = {r_remx[31:0], r_qx[31]};
    assign dv_ty  = {r_remy[31:0], r_qy[31]};
    assign dv_gx  = (dv_tx >= dv_len);
    assign dv_gy  = (dv_ty >= dv_len);

    assign set_cx = (r_qx > AXIS_ONE) ? AXIS_ONE : r_qx;
    assign set_cy = (r_qy > AXIS_ONE) ? AXIS_ONE : r_qy;

    // squared distance: x square held in r_sq, y square in the product register
    assign c_sum = r_sq + r_prod[65:0];

    // projection interval update
    assign pr_d    = r_d;
    assign pr_circ = r_circ[r_ps];
    assign pr_rr   = $signed({3'b0, r_rad[r_ps], 30'b0});
    assign pr_next = r_pi + CW'(1);
    always_comb begin
        if (pr_circ) begin
            pr_lo   = pr_d - pr_rr;
            pr_hi   = pr_d + pr_rr;
            pr_done = 1'b1;
        end else begin
            pr_lo   = ((r_pi == '0) || (pr_d < r_lo)) ? pr_d : r_lo;
            pr_hi   = ((r_pi == '0) || (pr_d > r_hi)) ? pr_d : r_hi;
            pr_done = (pr_next == r_cnt[r_ps]);
        end
    end

    assign ov_val  = 64'(r_top - r_bot);
    assign fin_dep = r_best[63:30];
    assign mtv_mag = r_prod[61:30];

    // load the result register when it is empty or being drained
    assign out_load = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
            r_circ[0] <= 1'b0;
            r_circ[1] <= 1'b0;
            r_rad[0] <= '0;
            r_rad[1] <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // hold a new result, or drop the old one once the sink takes it
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (in_circ) begin
                            r_circ[in_shape] <= 1'b1;
                            r_rad[in_shape]  <= s_axis_tdata[94:64];
                            r_cnt[in_shape]  <= CW'(1);
                        end else begin
                            r_circ[in_shape] <= 1'b0;
                            r_rad[in_shape]  <= '0;
                            r_cnt[in_shape]  <= (in_eff < CNT_MAX) ? in_eff + CW'(1)
                                                                   : in_eff;
                        end
                        if (s_axis_tlast) begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    if ((r_cnt[0] == '0) || (r_cnt[1] == '0)) begin
                        r_hit   <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_s     <= '0;
                        r_i     <= '0;
                        r_pass  <= 1'b0;
                        r_found <= 1'b0;
                        r_state <= S_EDGE;
                    end
                end
                // edge axes of each polygon
                S_EDGE: begin
                    if (r_s == 2'd2) begin
                        r_s     <= '0;
                        r_pass  <= 1'b1;
                        r_state <= S_CIRC;
                    end else if (r_circ[r_s[0]] || (r_i == r_cnt[r_s[0]])) begin
                        r_s <= r_s + 2'd1;
                        r_i <= '0;
                    end else begin
                        r_state <= S_E_RD1;
                    end
                end
                S_E_RD1: begin
                    r_px    <= rd_v.x;
                    r_py    <= rd_v.y;
                    r_state <= S_E_RD2;
                end
                S_E_RD2: begin
                    // perpendicular (-dy, dx)
                    r_dx    <= -34'(e_dy);
                    r_dy    <= 34'(e_dx);
                    r_state <= S_AX_ABS;
                end
                // circle axes: center toward nearest vertex of the other shape
                S_CIRC: begin
                    if (r_s == 2'd2) begin
                        r_state <= S_FIN;
                    end else if (!r_circ[r_s[0]]) begin
                        r_s <= r_s + 2'd1;
                    end else begin
                        r_i     <= '0;
                        r_have  <= 1'b0;
                        r_state <= S_C_CTR;
                    end
                end
                S_C_CTR: begin
                    r_px    <= rd_v.x;
                    r_py    <= rd_v.y;
                    r_state <= S_C_RD;
                end
                S_C_RD: begin
                    if (r_i == r_cnt[~r_s[0]]) begin
                        if (r_have) begin
                            r_dx    <= 34'(r_bdx);
                            r_dy    <= 34'(r_bdy);
                            r_state <= S_AX_ABS;
                        end else begin
                            r_s     <= r_s + 2'd1;
                            r_state <= S_CIRC;
                        end
                    end else begin
                        r_state <= S_C_D;
                    end
                end
                S_C_D: begin
                    r_tdx   <= c_dx;
                    r_tdy   <= c_dy;
                    r_state <= S_C_SQX;
                end
                S_C_SQX: begin
                    r_state <= S_C_SQY;
                end
                S_C_SQY: begin
                    r_sq    <= r_prod[65:0];
                    r_state <= S_C_CMP;
                end
                S_C_CMP: begin
                    // first vertex at the smallest distance wins
                    if (!r_have || (c_sum < r_bd2)) begin
                        r_have <= 1'b1;
                        r_bd2  <= c_sum;
                        r_bdx  <= r_tdx;
                        r_bdy  <= r_tdy;
                    end
                    r_i     <= r_i + CW'(1);
                    r_state <= S_C_RD;
                end
                // axis normalization
                S_AX_ABS: begin
                    r_mx <= ab_x[32:0];
                    r_my <= ab_y[32:0];
                    r_sx <= r_dx[33];
                    r_sy <= r_dy[33];
                    if ((r_dx == '0) && (r_dy == '0)) begin
                        // zero-length axis: skip it
                        if (r_pass) begin
                            r_s     <= r_s + 2'd1;
                            r_state <= S_CIRC;
                        end else begin
                            r_i     <= r_i + CW'(1);
                            r_state <= S_EDGE;
                        end
                    end else begin
                        r_state <= S_AX_NORM;
                    end
                end
                S_AX_NORM: begin
                    // bring the larger magnitude into [2^30, 2^31)
                    if (nm_m[32] || nm_m[31]) begin
                        r_mx <= r_mx >> 1;
                        r_my <= r_my >> 1;
                    end else if (!nm_m[30]) begin
                        r_mx <= r_mx << 1;
                        r_my <= r_my << 1;
                    end else begin
                        r_state <= S_AX_SQX;
                    end
                end
                S_AX_SQX: begin
                    r_state <= S_AX_SQY;
                end
                S_AX_SQY: begin
                    r_sq    <= r_prod[65:0];
                    r_state <= S_AX_SUM;
                end
                S_AX_SUM: begin
                    r_n     <= r_sq[63:0] + r_prod[63:0];
                    r_r     <= '0;
                    r_b     <= 64'h4000_0000_0000_0000;
                    r_state <= S_AX_SQRT;
                end
                S_AX_SQRT: begin
                    if (r_n >= sq_t) begin
                        r_n <= r_n - sq_t;
                    end
                    r_r <= sq_rn;
                    r_b <= r_b >> 2;
                    if (r_b[0]) begin
                        // dividends are the magnitudes times 2^30
                        r_remx  <= {4'b0, r_mx[30:2]};
                        r_qx    <= {r_mx[1:0], 30'b0};
                        r_remy  <= {4'b0, r_my[30:2]};
                        r_qy    <= {r_my[1:0], 30'b0};
                        r_k     <= '0;
                        r_state <= S_AX_DIV;
                    end
                end
                S_AX_DIV: begin
                    r_remx <= dv_gx ? dv_tx - dv_len : dv_tx;
                    r_qx   <= {r_qx[30:0], dv_gx};
                    r_remy <= dv_gy ? dv_ty - dv_len : dv_ty;
                    r_qy   <= {r_qy[30:0], dv_gy};
                    r_k    <= r_k + 5'd1;
                    if (r_k == 5'd31) begin
                        r_state <= S_AX_SET;
                    end
                end
                S_AX_SET: begin
                    r_ax    <= r_sx ? -$signed(set_cx) : $signed(set_cx);
                    r_ay    <= r_sy ? -$signed(set_cy) : $signed(set_cy);
                    r_ps    <= 1'b0;
                    r_pi    <= '0;
                    r_state <= S_PR_RD;
                end
                // projection of both shapes on the axis
                S_PR_RD: begin
                    r_state <= S_PR_MX;
                end
                S_PR_MX: begin
                    r_vy    <= rd_v.y;
                    r_state <= S_PR_MY;
                end
                S_PR_MY: begin
                    r_pacc  <= r_prod[63:0];
                    r_state <= S_PR_ACC;
                end
                S_PR_ACC: begin
                    r_d     <= r_pacc + r_prod[63:0];
                    r_state <= S_PR_UPD;
                end
                S_PR_UPD: begin
                    if (pr_done) begin
                        if (!r_ps) begin
                            r_alo   <= pr_lo;
                            r_ahi   <= pr_hi;
                            r_ps    <= 1'b1;
                            r_pi    <= '0;
                            r_state <= S_PR_RD;
                        end else begin
                            r_lo    <= pr_lo;
                            r_hi    <= pr_hi;
                            r_state <= S_OV;
                        end
                    end else begin
                        r_lo    <= pr_lo;
                        r_hi    <= pr_hi;
                        r_pi    <= pr_next;
                        r_state <= S_PR_RD;
                    end
                end
                S_OV: begin
                    // touching or a gap separates the shapes
                    if ((r_alo >= r_hi) || (r_ahi <= r_lo)) begin
                        r_hit   <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_top    <= (r_ahi < r_hi) ? r_ahi : r_hi;
                        r_bot    <= (r_alo > r_lo) ? r_alo : r_lo;
                        r_dirpos <= (r_alo < r_lo);
                        r_state  <= S_OV2;
                    end
                end
                S_OV2: begin
                    if (!r_found || (ov_val < r_best)) begin
                        r_found <= 1'b1;
                        r_best  <= ov_val;
                        r_bax   <= r_ax;
                        r_bay   <= r_ay;
                        r_bdir  <= r_dirpos;
                    end
                    if (r_pass) begin
                        r_s     <= r_s + 2'd1;
                        r_state <= S_CIRC;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_EDGE;
                    end
                end
                // every axis overlaps: build depth and translation
                S_FIN: begin
                    r_hit <= 1'b1;
                    if (r_found) begin
                        r_depth <= (|fin_dep[33:31]) ? DEPTH_SAT : fin_dep[30:0];
                        r_state <= S_MX;
                    end else begin
                        r_depth <= DEPTH_SAT;
                        r_mtvx  <= '0;
                        r_mtvy  <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_MX: begin
                    r_state <= S_MY;
                end
                S_MY: begin
                    r_mtvx  <= (r_bax[31] ^ ~r_bdir) ? -mtv_mag : mtv_mag;
                    r_state <= S_MW;
                end
                S_MW: begin
                    r_mtvy  <= (r_bay[31] ^ ~r_bdir) ? -mtv_mag : mtv_mag;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the result register is free, then empty both shapes
                    if (out_load) begin
                        r_odata   <= r_hit ? {1'b0, r_depth, r_mtvy, r_mtvx} : '0;
                        r_ouser   <= r_hit;
                        r_cnt[0]  <= '0;
                        r_cnt[1]  <= '0;
                        r_circ[0] <= 1'b0;
                        r_circ[1] <= 1'b0;
                        r_rad[0]  <= '0;
                        r_rad[1]  <= '0;
                        r_state   <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SPCC_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "miss result carries nonzero payload")
    `SPCC_ASSERT_IMP(a_circle_one, i_clk, i_rst_n, r_circ[0] || r_circ[1], (!r_circ[0] || (r_cnt[0] == CW'(1))) && (!r_circ[1] || (r_cnt[1] == CW'(1))), "circle shape without exactly one entry")
    `SPCC_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, (r_cnt[0] <= CNT_MAX) && (r_cnt[1] <= CNT_MAX), "vertex count past capacity")
    `SPCC_ASSERT_NXT(a_out_load, i_clk, i_rst_n, (r_state == S_OUT) && (!r_ovalid || m_axis_tready), m_axis_tvalid && (r_state == S_IDLE), "result not loaded on free output")

endmodule

`default_nettype wire

// ===== tb/sat_polygon_circle_collision_tb.sv =====
// ----------------------------------------------------------------------------
// sat_polygon_circle_collision_tb
// Self-checking bench for the polygon/circle separating-axis block. Shape
// items stream in through the input port, and a local model predicts every
// result. Each output transfer is compared field by field, in order, with the
// oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sat_polygon_circle_collision_tb;

    localparam int NV = 16;

    typedef struct {
        bit          sid;
        bit          circ;
        logic [31:0] x;
        logic [31:0] y;
        logic [30:0] r;
        bit          last;
    } t_shape_item;

    typedef struct {
        bit          collide;
        logic [31:0] mtv_x;
        logic [31:0] mtv_y;
        logic [30:0] depth;
    } t_hit_report;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic [spcc_pkg::DATA_W-1:0]       s_data  = '0;
    logic [spcc_pkg::USER_IN_W-1:0]    s_user  = '0;
    logic                              s_last  = 1'b0;
    logic                              m_valid;
    logic                              m_ready = 1'b1;
    logic [spcc_pkg::DATA_W-1:0]       m_data;
    logic [spcc_pkg::USER_OUT_W-1:0]   m_user;

    sat_polygon_circle_collision #(.MAX_VERTICES(NV)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        // [31:0] x, [63:32] y, [94:64] radius, [95] zero
        .s_axis_tdata  (s_data),
        // [0] shape_id, [1] is_circle
        .s_axis_tuser  (s_user),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        // [31:0] mtv_x, [63:32] mtv_y, [94:64] depth, [95] zero
        .m_axis_tdata  (m_data),
        // [0] collide
        .m_axis_tuser  (m_user)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shape model: own copy of the stored shapes
    // ------------------------------------------------------------------
    logic [31:0] mdl_x [2*NV];
    logic [31:0] mdl_y [2*NV];
    int unsigned mdl_cnt  [2];
    bit          mdl_circ [2];
    logic [30:0] mdl_rad  [2];

    bit             best_found;
    logic [63:0]    best_ov;
    longint         best_ax, best_ay;
    bit             best_pos;

    t_shape_item pending_items[$];
    t_hit_report expected_hits[$];
    int  errors       = 0;
    int  hits_seen    = 0;
    int  collisions   = 0;
    int  items_taken  = 0;

    function automatic longint vxs(int s, int i);
        return longint'($signed(mdl_x[s*NV+i]));
    endfunction

    function automatic longint vys(int s, int i);
        return longint'($signed(mdl_y[s*NV+i]));
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Unit axis in Q2.30; zero direction gives no axis
    function automatic bit unit_axis(input longint dx, input longint dy,
                                     output longint ax, output longint ay);
        logic [63:0] mx, my, m, len, qx, qy;
        mx = dx < 0 ? 64'(-dx) : 64'(dx);
        my = dy < 0 ? 64'(-dy) : 64'(dy);
        m  = mx > my ? mx : my;
        ax = 0;
        ay = 0;
        if (m == 0) return 1'b0;
        while (m >= (64'h1 << 31)) begin mx >>= 1; my >>= 1; m >>= 1; end
        while (m <  (64'h1 << 30)) begin mx <<= 1; my <<= 1; m <<= 1; end
        len = isqrt64(mx * mx + my * my);
        qx  = (mx << 30) / len;
        qy  = (my << 30) / len;
        if (qx > (64'h1 << 30)) qx = 64'h1 << 30;
        if (qy > (64'h1 << 30)) qy = 64'h1 << 30;
        ax = dx < 0 ? -longint'(qx) : longint'(qx);
        ay = dy < 0 ? -longint'(qy) : longint'(qy);
        return 1'b1;
    endfunction

    function automatic void shadow(int s, longint ax, longint ay,
                                   output longint lo, output longint hi);
        longint d, rr;
        if (mdl_circ[s]) begin
            d  = vxs(s, 0) * ax + vys(s, 0) * ay;
            rr = longint'({1'b0, mdl_rad[s]}) * (64'sd1 <<< 30);
            lo = d - rr;
            hi = d + rr;
            return;
        end
        lo = vxs(s, 0) * ax + vys(s, 0) * ay;
        hi = lo;
        for (int i = 1; i < mdl_cnt[s]; i++) begin
            d = vxs(s, i) * ax + vys(s, i) * ay;
            if (d > hi) hi = d;
            if (d < lo) lo = d;
        end
    endfunction

    // Returns 0 when the axis separates the shapes
    function automatic bit axis_overlaps(longint ax, longint ay);
        longint alo, ahi, blo, bhi, top, bot;
        logic [63:0] ov;
        shadow(0, ax, ay, alo, ahi);
        shadow(1, ax, ay, blo, bhi);
        if (alo >= bhi || ahi <= blo) return 1'b0;
        top = ahi < bhi ? ahi : bhi;
        bot = alo > blo ? alo : blo;
        ov  = 64'(top) - 64'(bot);
        if (!best_found || ov < best_ov) begin
            best_found = 1'b1;
            best_ov    = ov;
            best_ax    = ax;
            best_ay    = ay;
            best_pos   = alo < blo;
        end
        return 1'b1;
    endfunction

    function automatic bit shapes_overlap();
        longint ax, ay, dx, dy, cx, cy, bdx, bdy;
        logic [63:0] mx, my, sq, lo, blo;
        bit hi, bhi, have;
        int j;
        best_found = 1'b0;
        for (int s = 0; s < 2; s++) begin
            if (mdl_circ[s]) continue;
            for (int i = 0; i < mdl_cnt[s]; i++) begin
                j  = (i + 1 == mdl_cnt[s]) ? 0 : i + 1;
                dx = vxs(s, j) - vxs(s, i);
                dy = vys(s, j) - vys(s, i);
                if (unit_axis(-dy, dx, ax, ay) && !axis_overlaps(ax, ay)) return 1'b0;
            end
        end
        for (int s = 0; s < 2; s++) begin
            if (!mdl_circ[s]) continue;
            have = 1'b0; bhi = 1'b0; blo = 0; bdx = 0; bdy = 0;
            cx = vxs(s, 0);
            cy = vys(s, 0);
            // squared distance kept as 64 bits plus one carry, wrapping squares
            for (int i = 0; i < mdl_cnt[1-s]; i++) begin
                dx = vxs(1-s, i) - cx;
                dy = vys(1-s, i) - cy;
                mx = dx < 0 ? 64'(-dx) : 64'(dx);
                my = dy < 0 ? 64'(-dy) : 64'(dy);
                sq = mx * mx;
                lo = sq + my * my;
                hi = lo < sq;
                if (!have || hi < bhi || (hi == bhi && lo < blo)) begin
                    have = 1'b1; bhi = hi; blo = lo; bdx = dx; bdy = dy;
                end
            end
            if (have && unit_axis(bdx, bdy, ax, ay) && !axis_overlaps(ax, ay))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] push_comp(longint a, logic [63:0] depth);
        logic [63:0] mag;
        bit neg;
        mag = (64'(a < 0 ? -a : a) * depth) >> 30;
        neg = (a < 0) != !best_pos;
        return neg ? 32'(64'd0 - mag) : mag[31:0];
    endfunction

    // Advance the model by one accepted item; queue a report on last
    function automatic void absorb_item(t_shape_item it);
        int s;
        t_hit_report rep;
        logic [63:0] depth;
        s = it.sid;
        if (it.circ) begin
            mdl_circ[s]  = 1'b1;
            mdl_rad[s]   = it.r;
            mdl_x[s*NV]  = it.x;
            mdl_y[s*NV]  = it.y;
            mdl_cnt[s]   = 1;
        end else begin
            if (mdl_circ[s]) begin
                mdl_circ[s] = 1'b0;
                mdl_rad[s]  = '0;
                mdl_cnt[s]  = 0;
            end
            if (mdl_cnt[s] < NV) begin
                mdl_x[s*NV+mdl_cnt[s]] = it.x;
                mdl_y[s*NV+mdl_cnt[s]] = it.y;
                mdl_cnt[s]++;
            end
        end
        if (!it.last) return;
        rep = '{1'b0, '0, '0, '0};
        if (mdl_cnt[0] != 0 && mdl_cnt[1] != 0 && shapes_overlap()) begin
            rep.collide = 1'b1;
            if (best_found) begin
                depth = best_ov >> 30;
                if (depth > 64'h7FFF_FFFF) depth = 64'h7FFF_FFFF;
                rep.mtv_x = push_comp(best_ax, depth);
                rep.mtv_y = push_comp(best_ay, depth);
                rep.depth = depth[30:0];
            end else begin
                rep.depth = spcc_pkg::DEPTH_SAT;
            end
        end
        expected_hits.insert(expected_hits.size(), rep);
        mdl_cnt  = '{0, 0};
        mdl_circ = '{1'b0, 1'b0};
        mdl_rad  = '{31'd0, 31'd0};
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    int oct_kx [8] = '{1000, 707, 0, -707, -1000, -707, 0, 707};
    int oct_ky [8] = '{0, 707, 1000, 707, 0, -707, -1000, -707};

    task automatic add_item(bit sid, bit circ, logic [31:0] x, logic [31:0] y,
                            logic [30:0] r, bit last);
        t_shape_item it;
        it = '{sid, circ, x, y, r, last};
        pending_items.insert(pending_items.size(), it);
    endtask

    // Convex polygon from an ordered subset of octagon corners
    task automatic add_polygon(bit sid, longint cx, longint cy, longint rad,
                               bit last);
        int pick[$];
        int mask;
        do mask = $urandom_range(1, 255); while ($countones(mask) < 3);
        for (int k = 0; k < 8; k++) if (mask[k]) pick.insert(pick.size(), k);
        if ($urandom_range(0, 1)) pick.reverse();
        foreach (pick[k])
            add_item(sid, 1'b0, 32'(cx + rad * oct_kx[pick[k]] / 1000),
                     32'(cy + rad * oct_ky[pick[k]] / 1000),
                     31'($urandom), last && k == pick.size() - 1);
    endtask

    task automatic add_shape(bit sid, bit circ, longint cx, longint cy,
                             longint rad, bit last);
        if (circ) add_item(sid, 1'b1, 32'(cx), 32'(cy), 31'(rad), last);
        else      add_polygon(sid, cx, cy, rad, last);
    endtask

    task automatic add_random_frame();
        longint cx, cy, r0, r1, off;
        bit c0, c1;
        int shift;
        shift = $urandom_range(4, 26);
        cx = longint'($signed(32'($urandom))) >>> 4;
        cy = longint'($signed(32'($urandom))) >>> 4;
        r0 = $urandom_range(1, 1 << shift);
        r1 = $urandom_range(1, 1 << shift);
        off = r0 + r1;
        c0 = $urandom_range(0, 2) == 0;
        c1 = $urandom_range(0, 2) == 0;
        add_shape(0, c0, cx, cy, r0, 1'b0);
        add_shape(1, c1, cx + longint'($urandom_range(0, 32'(off))) - off / 2,
                  cy + longint'($urandom_range(0, 32'(off))) - off / 2, r1, 1'b1);
    endtask

    // Raw items with full-range fields, last now and then
    task automatic add_noise(int n);
        for (int k = 0; k < n; k++)
            add_item($urandom_range(0, 1), $urandom_range(0, 3) == 0, $urandom,
                     $urandom, 31'($urandom), $urandom_range(0, 5) == 0);
    endtask

    task automatic add_directed();
        // overlapping squares, then a gap, then circles touching
        add_item(0, 0, 0, 0, 0, 0); add_item(0, 0, 32'h0002_0000, 0, 0, 0);
        add_item(0, 0, 32'h0002_0000, 32'h0002_0000, 0, 0);
        add_item(0, 0, 0, 32'h0002_0000, 0, 0);
        add_polygon(1, 32'h0002_8000, 32'h0001_0000, 32'h0001_0000, 1);
        add_shape(0, 0, 0, 0, 32'h0001_0000, 0);
        add_shape(1, 0, 32'h0010_0000, 0, 32'h0001_0000, 1);
        add_shape(0, 1, 0, 0, 32'h0001_0000, 0);
        add_shape(1, 1, 32'h0002_0000, 0, 32'h0001_0000, 1);
        // concentric circles: no usable axis
        add_item(0, 1, 32'h0005_0000, 32'hFFFB_0000, 31'h0001_0000, 0);
        add_item(1, 1, 32'h0005_0000, 32'hFFFB_0000, 31'h7FFF_FFFF, 1);
        // empty second shape
        add_item(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1);
        // circle replaced by polygon, polygon replaced by circle
        add_item(0, 1, 0, 0, 31'h0003_0000, 0);
        add_polygon(0, 0, 0, 32'h0001_0000, 0);
        add_item(1, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        add_item(1, 1, 32'h0000_8000, 0, 31'h0001_0000, 1);
        // nine and eleven vertices, with coincident edge ends
        for (int k = 0; k < 18; k++)
            add_item(k % 2, 0, 32'(k * 32'h1000), 32'(k % 3 * 32'h2_0000), 0, 0);
        add_item(1, 0, 32'h8000_0000, 32'h8000_0000, 0, 0);
        add_item(1, 0, 32'h8000_0000, 32'h8000_0000, 0, 1);
        // circle center on the nearest vertex
        add_item(0, 1, 32'h0001_0000, 32'h0001_0000, 31'h0000_8000, 0);
        add_item(1, 0, 32'h0001_0000, 32'h0001_0000, 0, 1);
    endtask

    // ------------------------------------------------------------------
    // Input driver: one transfer per handshake, random idle bursts
    // ------------------------------------------------------------------
    int  in_gap = 0;
    bit  calm_tail;
    assign calm_tail = pending_items.size() < 250;

    always @(posedge i_clk) begin
        t_shape_item it;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                it = '{s_user[0], s_user[1], s_data[31:0], s_data[63:32],
                       s_data[94:64], s_last};
                absorb_item(it);
                items_taken++;
            end
            if (in_gap > 0) begin
                in_gap--;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                s_data  <= {1'b0, it.r, it.y, it.x};
                s_user  <= {it.circ, it.sid};
                s_last  <= it.last;
                s_valid <= 1'b1;
                if (!calm_tail && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 9);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: ready with idle bursts and one long hold-off
    // ------------------------------------------------------------------
    int  out_gap   = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!hold_done && hits_seen == 30) begin
            hold_done = 1'b1;
            hold_left = 6000;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            m_ready <= 1'b0;
        end else begin
            if (!calm_tail && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 9);
            m_ready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_hit_report want;
        if (i_rst_n && m_valid && m_ready) begin
            hits_seen++;
            if (expected_hits.size() == 0) begin
                errors++;
                $display("%0t: unexpected result collide=%0d data=%h", $time,
                         m_user[0], m_data);
            end else begin
                want = expected_hits.pop_front();
                if (want.collide) collisions++;
                if (m_user[0] !== want.collide) begin
                    errors++;
                    $display("%0t: collide expected %0d actual %0d", $time,
                             want.collide, m_user[0]);
                end
                if (m_data[31:0] !== want.mtv_x) begin
                    errors++;
                    $display("%0t: mtv_x expected %h actual %h", $time,
                             want.mtv_x, m_data[31:0]);
                end
                if (m_data[63:32] !== want.mtv_y) begin
                    errors++;
                    $display("%0t: mtv_y expected %h actual %h", $time,
                             want.mtv_y, m_data[63:32]);
                end
                if (m_data[94:64] !== want.depth) begin
                    errors++;
                    $display("%0t: depth expected %h actual %h", $time,
                             want.depth, m_data[94:64]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: build the stimulus, release reset, drain, report
    // ------------------------------------------------------------------
    initial begin
        mdl_cnt  = '{0, 0};
        mdl_circ = '{1'b0, 1'b0};
        mdl_rad  = '{31'd0, 31'd0};
        add_directed();
        while (pending_items.size() < 1900) begin
            if ($urandom_range(0, 9) == 0) add_noise($urandom_range(1, 12));
            else                           add_random_frame();
        end
        // close with a well-formed frame so nothing is left half loaded
        add_random_frame();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        wait (pending_items.size() == 0 && !s_valid && expected_hits.size() == 0);
        repeat (500) @(posedge i_clk);
        $display("%0d shape items loaded, %0d tests checked, %0d of them colliding",
                 items_taken, hits_seen, collisions);
        if (errors == 0 && expected_hits.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #200ms;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
